[sv/vcs_pkg.sv]
// Shared types and constants of the streaming valid 2D convolution block.
// Used by the channel interfaces and by every module of the block.
package vcs_pkg;

  localparam int KERNEL_MAX_DEF = 5;
  localparam int IMAGE_MAX_DEF  = 1024;

  localparam int VAL_W     = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 37;
  localparam int OUT_POS_W = 10;
  localparam int WIDX_W    = 5;
  localparam int KDIM_W    = 3;
  localparam int IDIM_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd3;

  localparam logic [KDIM_W-1:0] KERNEL_ROWS_RST = 3'd3;
  localparam logic [KDIM_W-1:0] KERNEL_COLS_RST = 3'd3;
  localparam logic [IDIM_W-1:0] IMAGE_ROWS_RST  = 11'd1024;
  localparam logic [IDIM_W-1:0] IMAGE_COLS_RST  = 11'd1024;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic                    op;
    logic [WIDX_W-1:0]       widx;
    logic signed [VAL_W-1:0] value;
    logic                    win_ok;
    logic                    last;
    logic [OUT_POS_W-1:0]    r0;
    logic [OUT_POS_W-1:0]    c0;
  } item_t;

endpackage

[sv/vcs_if.sv]
// Valid/ready channel interfaces of the convolution block: input items,
// result items and configuration writes. Depends on vcs_pkg.
interface vcs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [vcs_pkg::WIDX_W-1:0]       weight_index;
  logic signed [vcs_pkg::VAL_W-1:0] value;
  modport source (output valid, output op, output weight_index, output value, input ready);
  modport sink (input valid, input op, input weight_index, input value, output ready);
endinterface

interface vcs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [vcs_pkg::OUT_POS_W-1:0]        out_row;
  logic [vcs_pkg::OUT_POS_W-1:0]        out_col;
  logic signed [vcs_pkg::SUM_W-1:0]     sum;
  logic                                 frame_last;
  logic                                 dims_error;
  modport source (output valid, output out_row, output out_col, output sum,
                  output frame_last, output dims_error, input ready);
  modport sink (input valid, input out_row, input out_col, input sum,
                input frame_last, input dims_error, output ready);
endinterface

interface vcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vcs_pkg::CFG_IDX_W-1:0]   index;
  logic [vcs_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/vcs_dims.sv]
// Checks that the image size is a multiple of the kernel size, from registered
// quotients into a registered error flag. Depends on vcs_pkg.
module vcs_dims #(
  parameter int KERNEL_MAX = vcs_pkg::KERNEL_MAX_DEF,
  parameter int IMAGE_MAX  = vcs_pkg::IMAGE_MAX_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(KERNEL_MAX+1)-1:0]       kr_i,
  input  logic [$clog2(KERNEL_MAX+1)-1:0]       kc_i,
  input  logic [$clog2(IMAGE_MAX+1)-1:0]        ir_i,
  input  logic [$clog2(IMAGE_MAX+1)-1:0]        ic_i,
  output logic                                  err_o
);
  import vcs_pkg::*;

  localparam int KE_W = $clog2(KERNEL_MAX+1);
  localparam int IE_W = $clog2(IMAGE_MAX+1);
  localparam int S    = IE_W + 4;
  localparam int PW   = IE_W + S + 1;
  localparam int CW   = IE_W + KE_W;

  logic [IE_W-1:0] rq_q [KERNEL_MAX+1];
  logic [IE_W-1:0] cq_q [KERNEL_MAX+1];
  logic            err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_q[0] <= '0;
      cq_q[0] <= '0;
    end else begin
      rq_q[0] <= '0;
      cq_q[0] <= '0;
    end
  end

  // Quotients by every possible kernel size, via a scaled reciprocal.
  for (genvar d = 1; d <= KERNEL_MAX; d++) begin : g_div
    localparam int M = ((1 << S) + d - 1) / d;
    logic [PW-1:0] rp, cp;
    assign rp = PW'(ir_i) * PW'(M);
    assign cp = PW'(ic_i) * PW'(M);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rq_q[d] <= '0;
        cq_q[d] <= '0;
      end else begin
        rq_q[d] <= rp[S +: IE_W];
        cq_q[d] <= cp[S +: IE_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else begin
      err_q <= (CW'(rq_q[kr_i]) * CW'(kr_i) != CW'(ir_i)) ||
               (CW'(cq_q[kc_i]) * CW'(kc_i) != CW'(ic_i));
    end
  end

  assign err_o = err_q;

endmodule

[sv/vcs_linebuf.sv]
// Raster position tracking and banked line store; delivers each item with
// the column of pixels above it. Depends on vcs_pkg.
module vcs_linebuf #(
  parameter int KERNEL_MAX = vcs_pkg::KERNEL_MAX_DEF,
  parameter int IMAGE_MAX  = vcs_pkg::IMAGE_MAX_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic [vcs_pkg::WIDX_W-1:0]            widx_i,
  input  logic signed [vcs_pkg::VAL_W-1:0]      value_i,
  input  logic                                  restart_i,
  input  logic [$clog2(KERNEL_MAX+1)-1:0]       kr_i,
  input  logic [$clog2(KERNEL_MAX+1)-1:0]       kc_i,
  input  logic [$clog2(IMAGE_MAX+1)-1:0]        ir_i,
  input  logic [$clog2(IMAGE_MAX+1)-1:0]        ic_i,
  output logic                                  s1_valid_o,
  input  logic                                  s1_ready_i,
  output vcs_pkg::item_t                        s1_item_o,
  output logic signed [vcs_pkg::VAL_W-1:0]      s1_col_o [KERNEL_MAX]
);
  import vcs_pkg::*;

  localparam int PW = (IMAGE_MAX > 1) ? $clog2(IMAGE_MAX) : 1;
  localparam int BW = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;

  logic [PW-1:0]    row_q, col_q, row_c, col_c;
  logic [BW-1:0]    bank_q, bank_c, bank1_q;
  logic             last_c, col_end, acc, pix;
  item_t            item_c, item1_q;
  logic             v1_q;
  logic [VAL_W-1:0] rd_q [KERNEL_MAX];

  always_comb begin
    // A shrunken frame size pulls the position back to the frame start.
    if (int'(row_q) >= int'(ir_i) || int'(col_q) >= int'(ic_i)) begin
      row_c  = '0;
      col_c  = '0;
      bank_c = '0;
    end else begin
      row_c  = row_q;
      col_c  = col_q;
      bank_c = bank_q;
    end
    col_end = int'(col_c) == int'(ic_i) - 1;
    last_c  = col_end && (int'(row_c) == int'(ir_i) - 1);
    item_c.op     = op_i;
    item_c.widx   = widx_i;
    item_c.value  = value_i;
    item_c.last   = last_c;
    item_c.win_ok = (int'(row_c) + 1 >= int'(kr_i)) && (int'(col_c) + 1 >= int'(kc_i));
    item_c.r0     = OUT_POS_W'(int'(row_c) + 1 - int'(kr_i));
    item_c.c0     = OUT_POS_W'(int'(col_c) + 1 - int'(kc_i));
  end

  assign in_ready_o = !v1_q || s1_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign pix        = acc && (op_i == OP_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= '0;
    end else if (restart_i) begin
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= '0;
    end else if (pix) begin
      if (last_c) begin
        row_q  <= '0;
        col_q  <= '0;
        bank_q <= '0;
      end else if (col_end) begin
        row_q  <= row_c + 1'b1;
        col_q  <= '0;
        bank_q <= (int'(bank_c) == KERNEL_MAX - 1) ? '0 : bank_c + 1'b1;
      end else begin
        row_q  <= row_c;
        col_q  <= col_c + 1'b1;
        bank_q <= bank_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (acc) begin
      v1_q <= 1'b1;
    end else if (s1_ready_i) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item1_q <= item_c;
      bank1_q <= bank_c;
    end
  end

  // One bank per kernel row; each bank holds one image row.
  for (genvar b = 0; b < KERNEL_MAX; b++) begin : g_bank
    logic [VAL_W-1:0] mem [IMAGE_MAX];
    always_ff @(posedge clk_i) begin
      if (pix) begin
        if (int'(bank_c) == b) begin
          mem[col_c] <= value_i;
        end
        rd_q[b] <= mem[col_c];
      end
    end
  end

  always_comb begin
    int idx;
    s1_col_o[0] = item1_q.value;
    for (int k = 1; k < KERNEL_MAX; k++) begin
      idx = (int'(bank1_q) >= k) ? int'(bank1_q) - k : int'(bank1_q) + KERNEL_MAX - k;
      s1_col_o[k] = $signed(rd_q[BW'(idx)]);
    end
  end

  assign s1_valid_o = v1_q;
  assign s1_item_o  = item1_q;

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix && !restart_i && !last_c && !col_end) |=> (col_q == $past(col_c) + 1'b1))
    else $error("pixel column did not advance by one");

endmodule

[sv/vcs_mac.sv]
// Window shift registers, kernel weight store and the parallel window
// multipliers. Depends on vcs_pkg.
module vcs_mac #(
  parameter int KERNEL_MAX = vcs_pkg::KERNEL_MAX_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(KERNEL_MAX+1)-1:0]       kr_i,
  input  logic [$clog2(KERNEL_MAX+1)-1:0]       kc_i,
  input  logic                                  s1_valid_i,
  output logic                                  s1_ready_o,
  input  vcs_pkg::item_t                        s1_item_i,
  input  logic signed [vcs_pkg::VAL_W-1:0]      s1_col_i [KERNEL_MAX],
  output logic                                  s3_valid_o,
  input  logic                                  s3_ready_i,
  output vcs_pkg::item_t                        s3_item_o,
  output logic signed [vcs_pkg::PROD_W-1:0]     s3_prod_o [KERNEL_MAX][KERNEL_MAX]
);
  import vcs_pkg::*;

  localparam int NW = KERNEL_MAX * KERNEL_MAX;
  localparam int SW = (NW > 1) ? $clog2(NW) : 1;

  logic                    v2_q, v3_q, t1, t2;
  item_t                   item2_q, item3_q;
  logic signed [VAL_W-1:0] win_q [KERNEL_MAX][KERNEL_MAX];
  logic signed [VAL_W-1:0] weights_q [NW];
  logic signed [VAL_W-1:0] wm [KERNEL_MAX][KERNEL_MAX];
  logic                    wuse [KERNEL_MAX][KERNEL_MAX];
  logic signed [PROD_W-1:0] prod_q [KERNEL_MAX][KERNEL_MAX];

  assign t2         = v2_q && (!v3_q || s3_ready_i);
  assign s1_ready_o = !v2_q || t2;
  assign t1         = s1_valid_i && s1_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (t1) begin
        v2_q <= 1'b1;
      end else if (t2) begin
        v2_q <= 1'b0;
      end
      if (t2) begin
        v3_q <= 1'b1;
      end else if (s3_ready_i) begin
        v3_q <= 1'b0;
      end
    end
  end

  // win_q[k][j] holds the pixel k rows up and j columns left of the newest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KERNEL_MAX; k++) begin
        for (int j = 0; j < KERNEL_MAX; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (t1 && s1_item_i.op == OP_PIXEL) begin
      for (int k = 0; k < KERNEL_MAX; k++) begin
        win_q[k][0] <= s1_col_i[k];
        for (int j = 1; j < KERNEL_MAX; j++) begin
          win_q[k][j] <= win_q[k][j-1];
        end
      end
    end
  end

  // Weight writes take effect in item order, at the multiplier stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) begin
        weights_q[i] <= '0;
      end
    end else if (t2 && item2_q.op == OP_WEIGHT && int'(item2_q.widx) < NW) begin
      weights_q[SW'(item2_q.widx)] <= item2_q.value;
    end
  end

  always_comb begin
    for (int k = 0; k < KERNEL_MAX; k++) begin
      for (int j = 0; j < KERNEL_MAX; j++) begin
        wuse[k][j] = (k < int'(kr_i)) && (j < int'(kc_i));
        if (wuse[k][j]) begin
          wm[k][j] = weights_q[SW'((int'(kr_i) - 1 - k) * int'(kc_i) + int'(kc_i) - 1 - j)];
        end else begin
          wm[k][j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (t2) begin
      item3_q <= item2_q;
      for (int k = 0; k < KERNEL_MAX; k++) begin
        for (int j = 0; j < KERNEL_MAX; j++) begin
          prod_q[k][j] <= wuse[k][j] ? PROD_W'(win_q[k][j] * wm[k][j]) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (t1) begin
      item2_q <= s1_item_i;
    end
  end

  assign s3_valid_o = v3_q;
  assign s3_item_o  = item3_q;
  assign s3_prod_o  = prod_q;

endmodule

[sv/vcs_sum.sv]
// Two-stage adder tree over the window products and the result register.
// Depends on vcs_pkg.
module vcs_sum #(
  parameter int KERNEL_MAX = vcs_pkg::KERNEL_MAX_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  err_i,
  input  logic                                  s3_valid_i,
  output logic                                  s3_ready_o,
  input  vcs_pkg::item_t                        s3_item_i,
  input  logic signed [vcs_pkg::PROD_W-1:0]     s3_prod_i [KERNEL_MAX][KERNEL_MAX],
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [vcs_pkg::OUT_POS_W-1:0]         out_row_o,
  output logic [vcs_pkg::OUT_POS_W-1:0]         out_col_o,
  output logic signed [vcs_pkg::SUM_W-1:0]      sum_o,
  output logic                                  frame_last_o,
  output logic                                  dims_error_o
);
  import vcs_pkg::*;

  logic                    v4_q, ov_q, t3, t4, emit4;
  item_t                   item4_q;
  logic signed [SUM_W-1:0] rs_q [KERNEL_MAX];
  logic signed [SUM_W-1:0] rs_c [KERNEL_MAX];
  logic signed [SUM_W-1:0] total;
  logic [OUT_POS_W-1:0]    row_q, col_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    last_q, err_q;

  assign emit4      = (item4_q.op == OP_PIXEL) && (err_i || item4_q.win_ok);
  assign t4         = v4_q && (!emit4 || !ov_q || out_ready_i);
  assign s3_ready_o = !v4_q || t4;
  assign t3         = s3_valid_i && s3_ready_o;

  always_comb begin
    for (int k = 0; k < KERNEL_MAX; k++) begin
      rs_c[k] = '0;
      for (int j = 0; j < KERNEL_MAX; j++) begin
        rs_c[k] = rs_c[k] + SUM_W'(s3_prod_i[k][j]);
      end
    end
    total = '0;
    for (int k = 0; k < KERNEL_MAX; k++) begin
      total = total + rs_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (t3) begin
      item4_q <= s3_item_i;
      rs_q    <= rs_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (t3) begin
        v4_q <= 1'b1;
      end else if (t4) begin
        v4_q <= 1'b0;
      end
      if (t4 && emit4) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // A size mismatch turns every pixel into a bare error result.
  always_ff @(posedge clk_i) begin
    if (t4 && emit4) begin
      last_q <= item4_q.last;
      err_q  <= err_i;
      if (err_i) begin
        row_q <= '0;
        col_q <= '0;
        sum_q <= '0;
      end else begin
        row_q <= item4_q.r0;
        col_q <= item4_q.c0;
        sum_q <= total;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign sum_o        = sum_q;
  assign frame_last_o = last_q;
  assign dims_error_o = err_q;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && err_q) |-> (sum_q == '0 && row_q == '0 && col_q == '0))
    else $error("error result carries a nonzero sum or position");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(v4_q && emit4))
    else $error("result appeared without a producing item");

endmodule

[sv/valid_conv2d_stream.sv]
// Top level of the streaming valid 2D convolution block: configuration
// registers and the pipeline. Depends on vcs_pkg, vcs_if and all vcs_ modules.
//
// Kernel weights (op 0) and raster pixels (op 1) share one input channel and
// are taken at one item per clock unless output stalls; all window multiplies
// run in parallel. A result passes the line store, window, product, row-sum
// and result registers. The line store is KERNEL_MAX banks of IMAGE_MAX pixels,
// one bank port each, and needs no clearing after reset. Any configuration
// write restarts the frame; size check settles via size, quotient, error regs.
module valid_conv2d_stream #(
  parameter int KERNEL_MAX = vcs_pkg::KERNEL_MAX_DEF,
  parameter int IMAGE_MAX  = vcs_pkg::IMAGE_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vcs_in_if.sink    in_i,
  vcs_out_if.source out_o,
  vcs_cfg_if.sink   cfg_i
);
  import vcs_pkg::*;

  localparam int KE_W = $clog2(KERNEL_MAX+1);
  localparam int IE_W = $clog2(IMAGE_MAX+1);

  logic [KDIM_W-1:0] kernel_rows_q, kernel_cols_q;
  logic [IDIM_W-1:0] image_rows_q, image_cols_q;
  logic [KE_W-1:0]   kr, kc;
  logic [IE_W-1:0]   ir, ic;
  logic              cfg_we, err;

  logic                    s1_valid, s1_ready, s3_valid, s3_ready;
  item_t                   s1_item, s3_item;
  logic signed [VAL_W-1:0] s1_col [KERNEL_MAX];
  logic signed [PROD_W-1:0] s3_prod [KERNEL_MAX][KERNEL_MAX];

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_rows_q <= KERNEL_ROWS_RST;
      kernel_cols_q <= KERNEL_COLS_RST;
      image_rows_q  <= IMAGE_ROWS_RST;
      image_cols_q  <= IMAGE_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_i.index)
        REG_KERNEL_ROWS: kernel_rows_q <= cfg_i.data[KDIM_W-1:0];
        REG_KERNEL_COLS: kernel_cols_q <= cfg_i.data[KDIM_W-1:0];
        REG_IMAGE_ROWS:  image_rows_q  <= cfg_i.data;
        REG_IMAGE_COLS:  image_cols_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range sizes are clamped to the supported range.
  always_comb begin
    if (kernel_rows_q == '0) kr = KE_W'(1);
    else if (int'(kernel_rows_q) > KERNEL_MAX) kr = KE_W'(KERNEL_MAX);
    else kr = KE_W'(kernel_rows_q);
    if (kernel_cols_q == '0) kc = KE_W'(1);
    else if (int'(kernel_cols_q) > KERNEL_MAX) kc = KE_W'(KERNEL_MAX);
    else kc = KE_W'(kernel_cols_q);
    if (image_rows_q == '0) ir = IE_W'(1);
    else if (int'(image_rows_q) > IMAGE_MAX) ir = IE_W'(IMAGE_MAX);
    else ir = IE_W'(image_rows_q);
    if (image_cols_q == '0) ic = IE_W'(1);
    else if (int'(image_cols_q) > IMAGE_MAX) ic = IE_W'(IMAGE_MAX);
    else ic = IE_W'(image_cols_q);
  end

  vcs_dims #(.KERNEL_MAX(KERNEL_MAX), .IMAGE_MAX(IMAGE_MAX)) u_dims (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kr_i   (kr),
    .kc_i   (kc),
    .ir_i   (ir),
    .ic_i   (ic),
    .err_o  (err)
  );

  vcs_linebuf #(.KERNEL_MAX(KERNEL_MAX), .IMAGE_MAX(IMAGE_MAX)) u_linebuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .op_i       (in_i.op),
    .widx_i     (in_i.weight_index),
    .value_i    (in_i.value),
    .restart_i  (cfg_we),
    .kr_i       (kr),
    .kc_i       (kc),
    .ir_i       (ir),
    .ic_i       (ic),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_item_o  (s1_item),
    .s1_col_o   (s1_col)
  );

  vcs_mac #(.KERNEL_MAX(KERNEL_MAX)) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kr_i       (kr),
    .kc_i       (kc),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_item_i  (s1_item),
    .s1_col_i   (s1_col),
    .s3_valid_o (s3_valid),
    .s3_ready_i (s3_ready),
    .s3_item_o  (s3_item),
    .s3_prod_o  (s3_prod)
  );

  vcs_sum #(.KERNEL_MAX(KERNEL_MAX)) u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .err_i        (err),
    .s3_valid_i   (s3_valid),
    .s3_ready_o   (s3_ready),
    .s3_item_i    (s3_item),
    .s3_prod_i    (s3_prod),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_row_o    (out_o.out_row),
    .out_col_o    (out_o.out_col),
    .sum_o        (out_o.sum),
    .frame_last_o (out_o.frame_last),
    .dims_error_o (out_o.dims_error)
  );

endmodule
